// File: src/bgi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bgi_pkg;

  localparam int VAL_W   = 32;
  localparam int IDX_W   = 6;
  localparam int PTS_W   = 7;
  localparam int ADDR_W  = 2 * IDX_W;

  // Serial multiplier: 64-bit multiplicand, 32-bit multiplier.
  localparam int MCAND_W = 64;
  localparam int MPLR_W  = 32;
  localparam int PROD_W  = MCAND_W + MPLR_W;

  // Serial divider: 97-bit numerator magnitude, 64-bit divisor.
  localparam int NUM_W   = 97;
  localparam int DEN_W   = 64;
  localparam int ACC_W   = NUM_W + 1;

  localparam logic [1:0] REQ_LOAD_X = 2'd0;
  localparam logic [1:0] REQ_LOAD_Y = 2'd1;
  localparam logic [1:0] REQ_LOAD_T = 2'd2;
  localparam logic [1:0] REQ_QUERY  = 2'd3;

  localparam logic [1:0] ST_INSIDE  = 2'd0;
  localparam logic [1:0] ST_CLAMPED = 2'd1;
  localparam logic [1:0] ST_ZERO    = 2'd2;
  localparam logic [1:0] ST_SAT     = 2'd3;

  localparam logic CFG_X_POINTS = 1'b0;
  localparam logic CFG_Y_POINTS = 1'b1;

  localparam logic [PTS_W-1:0] PTS_MIN = 7'd2;
  localparam logic [PTS_W-1:0] PTS_MAX = 7'd64;

  typedef struct packed {
    logic                start;
    logic [MCAND_W-1:0]  mcand;
    logic [MPLR_W-1:0]   mplier;
  } mul_req_t;

  typedef struct packed {
    logic                start;
    logic [NUM_W-1:0]    num;
    logic [DEN_W-1:0]    den;
  } div_req_t;

endpackage
`default_nettype wire

// File: src/bgi_serial_mul.sv
`timescale 1ns / 1ps
`default_nettype none
module bgi_serial_mul
  import bgi_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire mul_req_t          req_i,
  output logic                   done_o,
  output logic [PROD_W-1:0]      prod_o
);

  logic [PROD_W-1:0]   prod_q, prod_d;
  logic [MCAND_W-1:0]  mcand_q;
  logic [4:0]          cnt_q, cnt_d;
  logic                active_q, active_d;
  logic                done_q, done_d;
  logic [MCAND_W:0]    sum;

  // One multiplier bit per cycle: add the multiplicand into the upper half and shift right.
  always_comb begin
    sum = {1'b0, prod_q[PROD_W-1:MPLR_W]} + (prod_q[0] ? {1'b0, mcand_q} : '0);
    prod_d   = prod_q;
    cnt_d    = cnt_q;
    active_d = active_q;
    done_d   = 1'b0;
    if (req_i.start) begin
      prod_d   = {{MCAND_W{1'b0}}, req_i.mplier};
      cnt_d    = '0;
      active_d = 1'b1;
    end else if (active_q) begin
      prod_d = {sum, prod_q[MPLR_W-1:1]};
      cnt_d  = cnt_q + 5'd1;
      if (cnt_q == 5'(MPLR_W - 1)) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      done_q   <= done_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (req_i.start) begin
      mcand_q <= req_i.mcand;
    end
  end

  assign done_o = done_q;
  assign prod_o = prod_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !active_q) else $error("multiplier restarted while running");
  a_done_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(active_q)) else $error("multiplier done without a run");

endmodule
`default_nettype wire

// File: src/bgi_serial_div.sv
`timescale 1ns / 1ps
`default_nettype none
module bgi_serial_div
  import bgi_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire div_req_t          req_i,
  output logic                   done_o,
  output logic [NUM_W-1:0]       quot_o
);

  logic [DEN_W+NUM_W-1:0] rq_q, rq_d;
  logic [DEN_W-1:0]       den_q;
  logic [6:0]             cnt_q, cnt_d;
  logic                   active_q, active_d;
  logic                   done_q, done_d;
  logic [DEN_W:0]         trial;
  logic                   ge;
  logic [DEN_W:0]         diff;

  // Restoring division, one quotient bit per cycle; the quotient shifts in below the remainder.
  always_comb begin
    trial    = rq_q[DEN_W+NUM_W-1:NUM_W-1];
    ge       = trial >= {1'b0, den_q};
    diff     = trial - {1'b0, den_q};
    rq_d     = rq_q;
    cnt_d    = cnt_q;
    active_d = active_q;
    done_d   = 1'b0;
    if (req_i.start) begin
      rq_d     = {{DEN_W{1'b0}}, req_i.num};
      cnt_d    = '0;
      active_d = 1'b1;
    end else if (active_q) begin
      rq_d  = {(ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0]), rq_q[NUM_W-2:0], ge};
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'(NUM_W - 1)) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      done_q   <= done_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rq_q <= rq_d;
    if (req_i.start) begin
      den_q <= req_i.den;
    end
  end

  assign done_o = done_q;
  assign quot_o = rq_q[NUM_W-1:0];

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !active_q) else $error("divider restarted while running");
  a_nonzero_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> req_i.den != '0) else $error("divider started with zero divisor");

endmodule
`default_nettype wire

// File: src/bilinear_grid_interpolator_top.sv
// Channel   Direction  Handshake                 Payload
// request   in         start & !busy             req_type_i, index_x_i, index_y_i,
//                                                load_value_i, coord_x_i, coord_y_i
// result    out        result_valid_o, 1 cycle   interp_value_o, cell_x_o, cell_y_o, status_o
// config    in         cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// A load transaction is written at its accept edge and busy stays low.
// A query stays busy through up to 6 bisection steps, the fetch of the bracket, four terms
// (a table read and two 32-step serial multiplications each), a serial multiplication for
// the divisor, the division and a final state that registers the result.
// Zero-width cells skip the arithmetic and go from the preparation state to that final state.
// Reset clears the control state and sets both point counts to 2; the stores are not cleared.
// The result is shown for exactly one cycle; the receiver cannot stall it.
`timescale 1ns / 1ps
`default_nettype none
module bilinear_grid_interpolator_top
  import bgi_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [1:0]              req_type_i,
  input  wire logic [IDX_W-1:0]        index_x_i,
  input  wire logic [IDX_W-1:0]        index_y_i,
  input  wire logic signed [VAL_W-1:0] load_value_i,
  input  wire logic signed [VAL_W-1:0] coord_x_i,
  input  wire logic signed [VAL_W-1:0] coord_y_i,
  input  wire logic                    cfg_we_i,
  input  wire logic                    cfg_idx_i,
  input  wire logic [PTS_W-1:0]        cfg_wdata_i,
  output logic                         result_valid_o,
  output logic signed [VAL_W-1:0]      interp_value_o,
  output logic [IDX_W-1:0]             cell_x_o,
  output logic [IDX_W-1:0]             cell_y_o,
  output logic [1:0]                   status_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_BIS_RD = 4'd1;
  localparam logic [3:0] S_BIS_CM = 4'd2;
  localparam logic [3:0] S_BND_LO = 4'd3;
  localparam logic [3:0] S_BND_HI = 4'd4;
  localparam logic [3:0] S_BND_CP = 4'd5;
  localparam logic [3:0] S_PREP   = 4'd6;
  localparam logic [3:0] S_T_RD   = 4'd7;
  localparam logic [3:0] S_T_M1   = 4'd8;
  localparam logic [3:0] S_T_W1   = 4'd9;
  localparam logic [3:0] S_T_M2   = 4'd10;
  localparam logic [3:0] S_T_W2   = 4'd11;
  localparam logic [3:0] S_D_M    = 4'd12;
  localparam logic [3:0] S_D_W    = 4'd13;
  localparam logic [3:0] S_DV_W   = 4'd14;
  localparam logic [3:0] S_FIN    = 4'd15;

  logic signed [VAL_W-1:0] x_mem [2**IDX_W];
  logic signed [VAL_W-1:0] y_mem [2**IDX_W];
  logic signed [VAL_W-1:0] t_mem [2**ADDR_W];

  logic [3:0]              state_q;
  logic [PTS_W-1:0]        xn_q, yn_q, cfg_clamped;
  logic signed [VAL_W-1:0] cx_q, cy_q, xg_rd_q, yg_rd_q, tb_rd_q;
  logic signed [VAL_W-1:0] xl_q, xh_q, yl_q, yh_q;
  logic [IDX_W-1:0]        xlo_q, xhi_q, ylo_q, yhi_q, xmid, ymid, xnlo, xnhi, ynlo, ynhi;
  logic                    xdone_q, ydone_q, xdone_n, ydone_n;
  logic [IDX_W-1:0]        x_raddr, y_raddr;
  logic [ADDR_W-1:0]       t_raddr;
  logic                    accept, load_x, load_y, load_t;

  logic signed [VAL_W:0]   ax0_q, ax1_q, by0_q, by1_q;
  logic [VAL_W-1:0]        dxmag_q, dymag_q;
  logic                    dsign_q, clamp_q, zero_q, tsign_q, nneg_q;
  logic [1:0]              k_q;
  logic signed [ACC_W-1:0] acc_q;

  logic signed [VAL_W-1:0] xv, yv;
  logic                    clamp_x, clamp_y;
  logic signed [VAL_W:0]   dx, dy, dxm, dym, ka, kb, kam, kbm, fm;
  logic [ACC_W-1:0]        term;
  logic [ACC_W-1:0]        acc_mag;

  mul_req_t                mul_req;
  div_req_t                div_req;
  logic                    mul_done, div_done;
  logic [PROD_W-1:0]       mul_prod;
  logic [NUM_W-1:0]        quot;

  logic                    qnz, qneg, qsat;
  logic [NUM_W-1:0]        lim;
  logic [VAL_W-1:0]        qval;

  assign accept = start && !busy;
  assign load_x = accept && req_type_i == REQ_LOAD_X;
  assign load_y = accept && req_type_i == REQ_LOAD_Y;
  assign load_t = accept && req_type_i == REQ_LOAD_T;

  // Point counts are held within [2, 64].
  always_comb begin
    cfg_clamped = cfg_wdata_i;
    if (cfg_wdata_i < PTS_MIN) begin
      cfg_clamped = PTS_MIN;
    end else if (cfg_wdata_i > PTS_MAX) begin
      cfg_clamped = PTS_MAX;
    end
  end

  // Bisection midpoints and the bracket after the compare.
  always_comb begin
    xmid = xlo_q + ((xhi_q - xlo_q) >> 1);
    ymid = ylo_q + ((yhi_q - ylo_q) >> 1);
    xnlo = xlo_q;
    xnhi = xhi_q;
    ynlo = ylo_q;
    ynhi = yhi_q;
    if (!xdone_q) begin
      if (xg_rd_q < cx_q) begin
        xnlo = xmid;
      end else begin
        xnhi = xmid;
      end
    end
    if (!ydone_q) begin
      if (yg_rd_q < cy_q) begin
        ynlo = ymid;
      end else begin
        ynhi = ymid;
      end
    end
    xdone_n = xdone_q || (IDX_W'(xnhi - xnlo) < IDX_W'(2));
    ydone_n = ydone_q || (IDX_W'(ynhi - ynlo) < IDX_W'(2));
  end

  always_comb begin
    unique case (state_q)
      S_BND_LO: begin
        x_raddr = xlo_q;
        y_raddr = ylo_q;
      end
      S_BND_HI: begin
        x_raddr = xhi_q;
        y_raddr = yhi_q;
      end
      default: begin
        x_raddr = xmid;
        y_raddr = ymid;
      end
    endcase
    t_raddr = {(k_q[0] ? xhi_q : xlo_q), (k_q[1] ? yhi_q : ylo_q)};
  end

  always_ff @(posedge clk_i) begin
    if (load_x) begin
      x_mem[index_x_i] <= load_value_i;
    end
    xg_rd_q <= x_mem[x_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (load_y) begin
      y_mem[index_y_i] <= load_value_i;
    end
    yg_rd_q <= y_mem[y_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (load_t) begin
      t_mem[{index_x_i, index_y_i}] <= load_value_i;
    end
    tb_rd_q <= t_mem[t_raddr];
  end

  // Clamping and cell widths, evaluated once both brackets are known.
  always_comb begin
    clamp_x = (cx_q > xh_q) || (cx_q < xl_q);
    clamp_y = (cy_q > yh_q) || (cy_q < yl_q);
    xv = (cx_q > xh_q) ? xh_q : ((cx_q < xl_q) ? xl_q : cx_q);
    yv = (cy_q > yh_q) ? yh_q : ((cy_q < yl_q) ? yl_q : cy_q);
    dx = {xh_q[VAL_W-1], xh_q} - {xl_q[VAL_W-1], xl_q};
    dy = {yh_q[VAL_W-1], yh_q} - {yl_q[VAL_W-1], yl_q};
    dxm = dx[VAL_W] ? -dx : dx;
    dym = dy[VAL_W] ? -dy : dy;
    ka  = k_q[0] ? ax1_q : ax0_q;
    kb  = k_q[1] ? by1_q : by0_q;
    kam = ka[VAL_W] ? -ka : ka;
    kbm = kb[VAL_W] ? -kb : kb;
    fm  = tb_rd_q[VAL_W-1] ? -{tb_rd_q[VAL_W-1], tb_rd_q} : {tb_rd_q[VAL_W-1], tb_rd_q};
    term    = {{(ACC_W-PROD_W){1'b0}}, mul_prod};
    acc_mag = acc_q[ACC_W-1] ? -acc_q : acc_q;
  end

  always_comb begin
    mul_req.start  = 1'b0;
    mul_req.mcand  = {{(MCAND_W-VAL_W){1'b0}}, fm[VAL_W-1:0]};
    mul_req.mplier = kam[VAL_W-1:0];
    unique case (state_q)
      S_T_M1: begin
        mul_req.start = 1'b1;
      end
      S_T_M2: begin
        mul_req.start  = 1'b1;
        mul_req.mcand  = mul_prod[MCAND_W-1:0];
        mul_req.mplier = kbm[VAL_W-1:0];
      end
      S_D_M: begin
        mul_req.start  = 1'b1;
        mul_req.mcand  = {{(MCAND_W-VAL_W){1'b0}}, dxmag_q};
        mul_req.mplier = dymag_q;
      end
      default: begin
        mul_req.start = 1'b0;
      end
    endcase
    div_req.start = (state_q == S_D_W) && mul_done;
    div_req.num   = acc_mag[NUM_W-1:0];
    div_req.den   = mul_prod[DEN_W-1:0];
  end

  bgi_serial_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  bgi_serial_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (quot)
  );

  // Sign and saturation of the quotient; a zero quotient is never negative.
  always_comb begin
    qnz  = quot != '0;
    qneg = nneg_q && qnz;
    lim  = qneg ? (NUM_W'(1) << (VAL_W - 1)) : ((NUM_W'(1) << (VAL_W - 1)) - NUM_W'(1));
    qsat = quot > lim;
    qval = qsat ? lim[VAL_W-1:0] : quot[VAL_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      xn_q           <= PTS_MIN;
      yn_q           <= PTS_MIN;
      result_valid_o <= 1'b0;
      xdone_q        <= 1'b0;
      ydone_q        <= 1'b0;
      k_q            <= '0;
    end else begin
      result_valid_o <= 1'b0;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_X_POINTS) begin
          xn_q <= cfg_clamped;
        end else begin
          yn_q <= cfg_clamped;
        end
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept && req_type_i == REQ_QUERY) begin
            xdone_q <= 1'b0;
            ydone_q <= 1'b0;
            state_q <= S_BIS_RD;
          end
        end
        S_BIS_RD: begin
          state_q <= S_BIS_CM;
        end
        S_BIS_CM: begin
          xdone_q <= xdone_n;
          ydone_q <= ydone_n;
          state_q <= (xdone_n && ydone_n) ? S_BND_LO : S_BIS_RD;
        end
        S_BND_LO: begin
          state_q <= S_BND_HI;
        end
        S_BND_HI: begin
          state_q <= S_BND_CP;
        end
        S_BND_CP: begin
          state_q <= S_PREP;
        end
        S_PREP: begin
          k_q     <= '0;
          state_q <= (dx == '0 || dy == '0) ? S_FIN : S_T_RD;
        end
        S_T_RD: begin
          state_q <= S_T_M1;
        end
        S_T_M1: begin
          state_q <= S_T_W1;
        end
        S_T_W1: begin
          if (mul_done) begin
            state_q <= S_T_M2;
          end
        end
        S_T_M2: begin
          state_q <= S_T_W2;
        end
        S_T_W2: begin
          if (mul_done) begin
            k_q     <= k_q + 2'd1;
            state_q <= (k_q == 2'd3) ? S_D_M : S_T_RD;
          end
        end
        S_D_M: begin
          state_q <= S_D_W;
        end
        S_D_W: begin
          if (mul_done) begin
            state_q <= S_DV_W;
          end
        end
        S_DV_W: begin
          if (div_done) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          result_valid_o <= 1'b1;
          state_q        <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        cx_q  <= coord_x_i;
        cy_q  <= coord_y_i;
        xlo_q <= '0;
        ylo_q <= '0;
        xhi_q <= IDX_W'(xn_q - PTS_W'(1));
        yhi_q <= IDX_W'(yn_q - PTS_W'(1));
      end
      S_BIS_CM: begin
        xlo_q <= xnlo;
        xhi_q <= xnhi;
        ylo_q <= ynlo;
        yhi_q <= ynhi;
      end
      S_BND_HI: begin
        xl_q <= xg_rd_q;
        yl_q <= yg_rd_q;
      end
      S_BND_CP: begin
        xh_q <= xg_rd_q;
        yh_q <= yg_rd_q;
      end
      S_PREP: begin
        ax0_q   <= {xh_q[VAL_W-1], xh_q} - {xv[VAL_W-1], xv};
        ax1_q   <= {xv[VAL_W-1], xv} - {xl_q[VAL_W-1], xl_q};
        by0_q   <= {yh_q[VAL_W-1], yh_q} - {yv[VAL_W-1], yv};
        by1_q   <= {yv[VAL_W-1], yv} - {yl_q[VAL_W-1], yl_q};
        dxmag_q <= dxm[VAL_W-1:0];
        dymag_q <= dym[VAL_W-1:0];
        dsign_q <= dx[VAL_W] ^ dy[VAL_W];
        clamp_q <= clamp_x || clamp_y;
        zero_q  <= (dx == '0) || (dy == '0);
        acc_q   <= '0;
      end
      S_T_M1: begin
        tsign_q <= tb_rd_q[VAL_W-1] ^ ka[VAL_W] ^ kb[VAL_W];
      end
      S_T_W2: begin
        if (mul_done) begin
          acc_q <= acc_q + (tsign_q ? -$signed(term) : $signed(term));
        end
      end
      S_D_W: begin
        if (mul_done) begin
          nneg_q <= acc_q[ACC_W-1] ^ dsign_q;
        end
      end
      S_FIN: begin
        cell_x_o <= xlo_q;
        cell_y_o <= ylo_q;
        if (zero_q) begin
          interp_value_o <= '0;
          status_o       <= ST_ZERO;
        end else begin
          interp_value_o <= qneg ? -$signed(qval) : $signed(qval);
          status_o       <= qsat ? ST_SAT : (clamp_q ? ST_CLAMPED : ST_INSIDE);
        end
      end
      default: begin
      end
    endcase
  end

  assign busy = state_q != S_IDLE;

  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy)) else $error("result without a query in flight");
  a_query_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && req_type_i == REQ_QUERY |=> busy) else $error("query did not start");
  a_load_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && req_type_i != REQ_QUERY |=> !busy) else $error("load made the block busy");
  a_zero_cell_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o == ST_ZERO |-> interp_value_o == '0)
    else $error("zero-width cell with a nonzero value");
  a_bracket_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_BND_LO |-> (xlo_q <= xhi_q) && (ylo_q <= yhi_q))
    else $error("bisection bracket inverted");

endmodule
`default_nettype wire
